// File: design/keyframe_sky_color_interpolator_assert.svh
`ifndef KEYFRAME_SKY_COLOR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_SKY_COLOR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define KSCI_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSCI_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ksci_pkg.sv
package ksci_pkg;

  localparam int ROM_KEYS   = 10;
  localparam int KEY_W      = 4;
  localparam int NUM_GROUPS = 6;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = 4;

  typedef logic [KEY_W-1:0]   key_idx_t;
  typedef logic [2:0]         group_t;
  typedef logic signed [15:0] q14_t;
  typedef logic [16:0]        ktime_t;

  localparam group_t GRP_ZENITH  = 3'd0;
  localparam group_t GRP_HORIZON = 3'd1;
  localparam group_t GRP_GROUND  = 3'd2;
  localparam group_t GRP_SUN     = 3'd3;
  localparam group_t GRP_DIR     = 3'd4;
  localparam group_t GRP_TIME    = 3'd5;

  localparam ktime_t      SPAN_MIN   = 17'd6;
  localparam logic [19:0] DIV3_RECIP = 20'd699051;
  localparam int          DIV3_SHIFT = 21;
  localparam logic [15:0] QUARTER    = 16'd16384;

  function automatic q14_t cq(int h);
    return q14_t'((h * 16384 + 50) / 100);
  endfunction

  function automatic ktime_t kt(int h);
    return ktime_t'((h * 65536 + 50) / 100);
  endfunction

  localparam ktime_t KEY_T [ROM_KEYS] = '{
    kt(0), kt(18), kt(22), kt(30), kt(50), kt(70), kt(78), kt(83), kt(87), kt(100)
  };

  localparam q14_t KEY_RGB [ROM_KEYS][4][3] = '{
    '{'{cq(0), cq(0), cq(5)},    '{cq(2), cq(2), cq(8)},
      '{cq(2), cq(1), cq(0)},    '{cq(0), cq(0), cq(0)}},
    '{'{cq(1), cq(1), cq(10)},   '{cq(5), cq(5), cq(12)},
      '{cq(3), cq(2), cq(1)},    '{cq(0), cq(0), cq(0)}},
    '{'{cq(5), cq(5), cq(20)},   '{cq(40), cq(20), cq(10)},
      '{cq(10), cq(6), cq(3)},   '{cq(100), cq(50), cq(10)}},
    '{'{cq(15), cq(30), cq(65)}, '{cq(70), cq(60), cq(40)},
      '{cq(12), cq(10), cq(7)},  '{cq(100), cq(80), cq(50)}},
    '{'{cq(10), cq(30), cq(75)}, '{cq(55), cq(65), cq(80)},
      '{cq(15), cq(12), cq(10)}, '{cq(100), cq(97), cq(90)}},
    '{'{cq(12), cq(28), cq(70)}, '{cq(65), cq(55), cq(35)},
      '{cq(12), cq(10), cq(7)},  '{cq(100), cq(80), cq(50)}},
    '{'{cq(5), cq(5), cq(20)},   '{cq(55), cq(25), cq(10)},
      '{cq(10), cq(6), cq(3)},   '{cq(100), cq(50), cq(10)}},
    '{'{cq(1), cq(1), cq(12)},   '{cq(8), cq(5), cq(18)},
      '{cq(3), cq(2), cq(1)},    '{cq(20), cq(5), cq(0)}},
    '{'{cq(0), cq(0), cq(6)},    '{cq(3), cq(3), cq(9)},
      '{cq(2), cq(1), cq(0)},    '{cq(0), cq(0), cq(0)}},
    '{'{cq(0), cq(0), cq(5)},    '{cq(2), cq(2), cq(8)},
      '{cq(2), cq(1), cq(0)},    '{cq(0), cq(0), cq(0)}}
  };

  localparam q14_t KEY_INT [ROM_KEYS] = '{
    cq(0), cq(0), cq(60), cq(100), cq(140), cq(100), cq(60), cq(10), cq(0), cq(0)
  };

endpackage

// File: design/ksci_sine.sv
module ksci_sine
  import ksci_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] phase,
  output q14_t        value
);

  localparam logic [14:0] COEF_A = 15'd25736;
  localparam logic [13:0] COEF_B = 14'd10512;
  localparam logic [10:0] COEF_C = 11'd1160;

  logic signed [16:0] fold;
  logic        [14:0] zin;
  logic        [28:0] zsq;

  logic [14:0] z1, z2, z3, z2_1, z2_2;
  logic        neg1, neg2, neg3;
  logic [13:0] inner2;
  logic [14:0] outer3;

  logic [25:0] p2;
  logic [28:0] p3;
  logic [29:0] p4;

  always_comb begin
    fold = 17'($signed(phase));
    if (fold > 17'sd16384) begin
      fold = 17'sd32768 - fold;
    end else if (fold < -17'sd16384) begin
      fold = -17'sd32768 - fold;
    end
    zin = fold[16] ? 15'(-fold) : fold[14:0];
    zsq = 29'(zin) * 29'(zin);
  end

  assign p2 = 26'(z2_1) * 26'(COEF_C);
  assign p3 = 29'(z2_2) * 29'(inner2);
  assign p4 = 30'(z3) * 30'(outer3);

  always_ff @(posedge clk) begin
    if (en) begin
      z1     <= zin;
      neg1   <= fold[16];
      z2_1   <= 15'((zsq + 29'd8192) >> 14);
      z2     <= z1;
      neg2   <= neg1;
      z2_2   <= z2_1;
      inner2 <= COEF_B - 14'((p2 + 26'd8192) >> 14);
      z3     <= z2;
      neg3   <= neg2;
      outer3 <= COEF_A - 15'((p3 + 29'd8192) >> 14);
      value  <= neg3 ? -q14_t'((p4 + 30'd8192) >> 14) : q14_t'((p4 + 30'd8192) >> 14);
    end
  end

endmodule

// File: design/keyframe_sky_color_interpolator.sv
// Sky color from a time of day: each accepted time_hours item yields six result items
// (zenith, horizon, ground, sun color, sun direction, normalized time) in that order,
// the last one flagged by last_of_run. The input goes through a nine-stage pipeline
// (wrap and divide, key search, a four-stage alpha divider in step with the sine
// evaluation, blend, sun scaling) into an output buffer that hands out one result per
// cycle while result_stall is low; the buffer reloads in the cycle its sixth result is
// taken and the pipeline keeps filling behind it.
`include "keyframe_sky_color_interpolator_assert.svh"

module keyframe_sky_color_interpolator
  import ksci_pkg::*;
#(
  parameter int NUM_KEYS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               time_valid,
  output logic               time_stall,
  input  logic signed [23:0] time_hours,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         group,
  output logic signed [15:0] first_value,
  output logic signed [15:0] second_value,
  output logic signed [15:0] third_value,
  output logic               last_of_run
);

  localparam int KEY_COUNT = (NUM_KEYS < ROM_KEYS) ? NUM_KEYS : ROM_KEYS;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] quo;
  } div_t;

  typedef struct packed {
    logic [15:0] t;
    key_idx_t    lo;
    ktime_t      span;
    logic        span_ok;
    logic        d_ge;
  } info_t;

  function automatic logic [1:0] wrap_mod3(logic [4:0] u);
    logic [5:0] v;
    v = 6'(u) + 6'd2;
    if (v >= 6'd18) v = v - 6'd18;
    if (v >= 6'd9)  v = v - 6'd9;
    if (v >= 6'd6)  v = v - 6'd6;
    if (v >= 6'd3)  v = v - 6'd3;
    return v[1:0];
  endfunction

  function automatic div_t div_steps(div_t cur, ktime_t span);
    div_t        nxt;
    logic [17:0] wide;
    nxt = cur;
    for (int k = 0; k < DIV_STEPS; k++) begin
      wide = {nxt.rem, 1'b0};
      if (wide >= {1'b0, span}) begin
        nxt.rem = 17'(wide - {1'b0, span});
        nxt.quo = {nxt.quo[14:0], 1'b1};
      end else begin
        nxt.rem = wide[16:0];
        nxt.quo = {nxt.quo[14:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  function automatic q14_t sat16(logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic q14_t blend(q14_t a, q14_t b, logic [16:0] alpha);
    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [35:0] sum;
    diff = 17'(b) - 17'(a);
    prod = diff * $signed({1'b0, alpha});
    sum  = 36'(a) + 36'((prod + 35'sd32768) >>> 16);
    return sat16(sum);
  endfunction

  logic adv, ser_load;

  // stage 1: wrap to one day
  logic        v1;
  logic [20:0] r1;
  // stage 2: fraction of a day
  logic        v2;
  logic [15:0] t2;
  logic [37:0] t2_prod;
  // stage 3: key search
  logic        v3;
  info_t       inf3;
  div_t        dv3;
  key_idx_t    lo_sel, hi_sel;
  logic        found;
  ktime_t      ta, tb, span_c, d_c;
  logic        tge_c, span_ok_c, d_ge_c;
  // alpha divider
  logic        v_d   [DIV_STAGES];
  div_t        dv_d  [DIV_STAGES];
  info_t       inf_d [DIV_STAGES];
  q14_t        sin_x, sin_y;
  // stage 8: blends
  logic        v8;
  q14_t        c8 [4][3];
  q14_t        int8, sx8, sy8, tq8;
  logic [16:0] alpha;
  key_idx_t    lo8, hi8;
  // stage 9: sun scaling
  logic               v9;
  q14_t               res9 [NUM_GROUPS][3];
  logic signed [31:0] sun_prod [3];
  // output buffer
  logic   ser_valid;
  group_t cnt;
  q14_t   ser [NUM_GROUPS][3];

  assign ser_load   = v9 && (!ser_valid || (!result_stall && cnt == GRP_TIME));
  assign adv        = !v9 || ser_load;
  assign time_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      for (int j = 0; j < DIV_STAGES; j++) v_d[j] <= 1'b0;
    end else if (adv) begin
      v1     <= time_valid;
      v2     <= v1;
      v3     <= v2;
      v_d[0] <= v3;
      for (int j = 1; j < DIV_STAGES; j++) v_d[j] <= v_d[j-1];
      v8     <= v_d[DIV_STAGES-1];
      v9     <= v8;
    end
  end

  assign t2_prod = 38'(r1[20:3]) * 38'(DIV3_RECIP);

  always_comb begin
    lo_sel = '0;
    found  = 1'b0;
    for (int i = 0; i < KEY_COUNT - 1; i++) begin
      if (!found && {1'b0, t2} >= KEY_T[i] && {1'b0, t2} <= KEY_T[i+1]) begin
        lo_sel = KEY_W'(i);
        found  = 1'b1;
      end
    end
    hi_sel    = KEY_W'(lo_sel + 1'b1);
    ta        = KEY_T[lo_sel];
    tb        = KEY_T[hi_sel];
    span_c    = (tb >= ta) ? ktime_t'(tb - ta) : '0;
    tge_c     = {1'b0, t2} >= ta;
    d_c       = ktime_t'({1'b0, t2} - ta);
    span_ok_c = (span_c > SPAN_MIN) && tge_c;
    d_ge_c    = d_c >= span_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1           <= {wrap_mod3({~time_hours[23], time_hours[22:19]}), time_hours[18:0]};
      t2           <= t2_prod[DIV3_SHIFT+15:DIV3_SHIFT];
      inf3.t       <= t2;
      inf3.lo      <= lo_sel;
      inf3.span    <= span_c;
      inf3.span_ok <= span_ok_c;
      inf3.d_ge    <= d_ge_c;
      dv3.rem      <= (span_ok_c && !d_ge_c) ? d_c : '0;
      dv3.quo      <= '0;
      dv_d[0]      <= div_steps(dv3, inf3.span);
      inf_d[0]     <= inf3;
      for (int j = 1; j < DIV_STAGES; j++) begin
        dv_d[j]  <= div_steps(dv_d[j-1], inf_d[j-1].span);
        inf_d[j] <= inf_d[j-1];
      end
    end
  end

  // sine latency matches the divider depth
  ksci_sine u_sin_x (
    .clk   (clk),
    .en    (adv),
    .phase (inf3.t),
    .value (sin_x)
  );

  ksci_sine u_sin_y (
    .clk   (clk),
    .en    (adv),
    .phase (16'(inf3.t - QUARTER)),
    .value (sin_y)
  );

  always_comb begin
    if (!inf_d[DIV_STAGES-1].span_ok) begin
      alpha = '0;
    end else if (inf_d[DIV_STAGES-1].d_ge) begin
      alpha = 17'h10000;
    end else begin
      alpha = {1'b0, dv_d[DIV_STAGES-1].quo};
    end
    lo8 = inf_d[DIV_STAGES-1].lo;
    hi8 = KEY_W'(lo8 + 1'b1);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) sun_prod[c] = c8[2'(GRP_SUN)][c] * int8;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 4; g++) begin
        for (int c = 0; c < 3; c++) begin
          c8[g][c] <= blend(KEY_RGB[lo8][g][c], KEY_RGB[hi8][g][c], alpha);
        end
      end
      int8 <= blend(KEY_INT[lo8], KEY_INT[hi8], alpha);
      sx8  <= sin_x;
      sy8  <= sin_y;
      tq8  <= q14_t'(({2'b0, inf_d[DIV_STAGES-1].t} + 18'd2) >> 2);
      for (int g = 0; g < 3; g++) begin
        for (int c = 0; c < 3; c++) res9[g][c] <= c8[g][c];
      end
      for (int c = 0; c < 3; c++) begin
        res9[GRP_SUN][c] <= sat16(36'((sun_prod[c] + 32'sd8192) >>> 14));
      end
      res9[GRP_DIR][0]  <= sx8;
      res9[GRP_DIR][1]  <= sy8;
      res9[GRP_DIR][2]  <= '0;
      res9[GRP_TIME][0] <= tq8;
      res9[GRP_TIME][1] <= '0;
      res9[GRP_TIME][2] <= '0;
    end
  end

  // output buffer, one result per cycle while result_stall is low
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      cnt       <= GRP_ZENITH;
    end else if (ser_load) begin
      ser_valid <= 1'b1;
      cnt       <= GRP_ZENITH;
    end else if (ser_valid && !result_stall) begin
      if (cnt == GRP_TIME) begin
        ser_valid <= 1'b0;
        cnt       <= GRP_ZENITH;
      end else begin
        cnt <= group_t'(cnt + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        for (int c = 0; c < 3; c++) ser[g][c] <= res9[g][c];
      end
    end
  end

  assign result_valid = ser_valid;
  assign group        = cnt;
  assign first_value  = ser[cnt][0];
  assign second_value = ser[cnt][1];
  assign third_value  = ser[cnt][2];
  assign last_of_run  = (cnt == GRP_TIME);

  `KSCI_CHECK_NEXT(a_cnt_step, result_valid && !result_stall && cnt != GRP_TIME, result_valid && cnt == group_t'($past(cnt) + 1'b1), "result group skipped")
  `KSCI_CHECK_NOW(a_load_free, ser_load, !ser_valid || (cnt == GRP_TIME && !result_stall), "output buffer overwritten")
  `KSCI_CHECK_NEXT(a_hold_tail, v9 && !adv, v9, "pipeline tail item lost")
  `KSCI_CHECK_NOW(a_cnt_range, result_valid, cnt <= GRP_TIME, "result group out of range")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ksci_pkg::*;

  typedef struct {
    group_t grp;
    q14_t   v0;
    q14_t   v1;
    q14_t   v2;
    logic   last;
  } sky_result_t;

  logic               clk;
  logic               rst;
  logic               time_valid;
  logic               time_stall;
  logic signed [23:0] time_hours;
  logic               result_valid;
  logic               result_stall;
  logic [2:0]         group;
  logic signed [15:0] first_value;
  logic signed [15:0] second_value;
  logic signed [15:0] third_value;
  logic               last_of_run;

  keyframe_sky_color_interpolator uut (
    .clk(clk), .rst(rst),
    .time_valid(time_valid), .time_stall(time_stall), .time_hours(time_hours),
    .result_valid(result_valid), .result_stall(result_stall),
    .group(group), .first_value(first_value), .second_value(second_value),
    .third_value(third_value), .last_of_run(last_of_run)
  );

  logic [23:0]  pending_times[$];
  sky_result_t  expected_colors[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           idle_pct;
  int           stall_pct;
  bit           hold_go = 1'b0;
  bit           hold_active = 1'b0;

  function automatic q14_t sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return q14_t'(v);
  endfunction

  function automatic q14_t mix(q14_t a, q14_t b, int unsigned alpha);
    longint acc;
    acc = longint'(a) * (65536 - longint'(alpha)) + longint'(b) * longint'(alpha) + 32768;
    return sat16(acc >>> 16);
  endfunction

  function automatic int sine14(int unsigned p);
    int q, z, z2, inner, outer, r;
    p = p & 32'hFFFF;
    q = (p >= 32768) ? int'(p) - 65536 : int'(p);
    if (q > 16384) q = 32768 - q;
    else if (q < -16384) q = -32768 - q;
    z = (q < 0) ? -q : q;
    z2 = (z * z + 8192) >>> 14;
    inner = 10512 - ((z2 * 1160 + 8192) >>> 14);
    outer = 25736 - ((z2 * inner + 8192) >>> 14);
    r = int'((longint'(z) * outer + 8192) >>> 14);
    return (q < 0) ? -r : r;
  endfunction

  task automatic predict_sky(logic [23:0] raw);
    int          s, r, lo, hi;
    int unsigned t, span, alpha;
    q14_t        c[3];
    q14_t        inten;
    longint      m;
    sky_result_t e;
    s = int'($signed(raw));
    r = s % 1572864;
    if (r < 0) r += 1572864;
    t = r / 24;
    lo = 0;
    hi = 1;
    alpha = 0;
    for (int i = 0; i < ROM_KEYS - 1; i++) begin
      if (t >= KEY_T[i] && t <= KEY_T[i+1]) begin
        lo = i;
        hi = i + 1;
        break;
      end
    end
    span = (KEY_T[hi] >= KEY_T[lo]) ? KEY_T[hi] - KEY_T[lo] : 0;
    if (span > 6 && t >= KEY_T[lo]) alpha = ((longint'(t - KEY_T[lo])) << 16) / span;
    if (alpha > 65536) alpha = 65536;
    for (int g = 0; g < 3; g++) begin
      for (int k = 0; k < 3; k++) c[k] = mix(KEY_RGB[lo][g][k], KEY_RGB[hi][g][k], alpha);
      e = '{group_t'(g), c[0], c[1], c[2], 1'b0};
      expected_colors.push_back(e);
    end
    inten = mix(KEY_INT[lo], KEY_INT[hi], alpha);
    for (int k = 0; k < 3; k++) begin
      m = longint'(mix(KEY_RGB[lo][3][k], KEY_RGB[hi][3][k], alpha)) * inten;
      c[k] = sat16((m + 8192) >>> 14);
    end
    expected_colors.push_back('{GRP_SUN, c[0], c[1], c[2], 1'b0});
    expected_colors.push_back('{GRP_DIR, q14_t'(sine14(t)), q14_t'(sine14(t + 65536 - 16384)),
                                16'sd0, 1'b0});
    expected_colors.push_back('{GRP_TIME, sat16((t + 2) >> 2), 16'sd0, 16'sd0, 1'b1});
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      time_valid <= 0;
      time_hours <= '0;
    end else if (time_valid && !time_stall) begin
      predict_sky(time_hours);
      if (pending_times.size() > 0 && $urandom_range(99) >= idle_pct) begin
        time_hours <= pending_times.pop_front();
      end else begin
        time_valid <= 0;
      end
    end else if (!time_valid && pending_times.size() > 0 && $urandom_range(99) >= idle_pct) begin
      time_hours <= pending_times.pop_front();
      time_valid <= 1;
    end
  end

  // long output hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result group %0d", group);
        end else begin
          sky_result_t e;
          e = expected_colors.pop_front();
          if (group !== e.grp || first_value !== e.v0 || second_value !== e.v1 ||
              third_value !== e.v2 || last_of_run !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       e.grp, e.v0, e.v1, e.v2, e.last, group, first_value,
                       second_value, third_value, last_of_run);
          end
        end
      end
      if (hold_active) begin
        result_stall <= 1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic add_random(int n);
    logic [23:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = 24'($urandom);
        1: v = 24'($urandom_range(1572863));
        2: v = 24'(-$urandom_range(1572864));
        default: v = 24'((KEY_T[$urandom_range(ROM_KEYS - 1)] * 24) + $urandom_range(48) - 24);
      endcase
      pending_times.push_back(v);
    end
  endtask

  task automatic drain();
    while (pending_times.size() > 0 || time_valid || expected_colors.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    rst <= 0;
    foreach (KEY_T[i]) pending_times.push_back(24'(KEY_T[i] * 24));
    pending_times.push_back(24'h7FFFFF);
    pending_times.push_back(24'h800000);
    pending_times.push_back(24'd1572864);
    pending_times.push_back(24'd1572863);
    pending_times.push_back(-24'd1);
    pending_times.push_back(-24'd1572864);
    pending_times.push_back(24'hFFFFFF ^ 24'h555555);
    pending_times.push_back(24'h555555);
    pending_times.push_back(24'd1);
    pending_times.push_back(24'(KEY_T[1] * 24 + 5 * 24));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 65) : 0;
      stall_pct = (ph == 2) ? 65 : ((ph == 3) ? 12 : 0);
      if (ph == 0) hold_go = 1'b1;
      add_random(75);
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    repeat (40) @(posedge clk);
    $display("tb: %0d results checked over directed key times, wrap extremes and random",
             results_seen);
    $display("tb: times under four idle and stall mixes with one long output hold-off");
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/ksci_pkg.sv
design/ksci_sine.sv
design/keyframe_sky_color_interpolator.sv
tb/tb.sv
